### sv/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types, codes and the micro-program of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int WIDTH = 64;
    localparam int PC_W  = 5;

    localparam logic [2:0] OPC_ADD  = 3'd0;
    localparam logic [2:0] OPC_SUB  = 3'd1;
    localparam logic [2:0] OPC_MUL  = 3'd2;
    localparam logic [2:0] OPC_DIV  = 3'd3;
    localparam logic [2:0] OPC_LT   = 3'd4;
    localparam logic [2:0] OPC_NORM = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_ZDEN = 2'd2;

    localparam logic [127:0] LIM = 128'd1 << (WIDTH - 1);

    typedef enum logic [3:0] {
        R_NA, R_DA, R_NB, R_DB, R_G1, R_G2, R_X, R_Y, R_REM, R_T, R_P, R_Q
    } reg_id_t;

    typedef enum logic [2:0] {
        U_GCD, U_DIV, U_MUL, U_COMB, U_ZEND, U_FRAC, U_LESS
    } uop_kind_t;

    typedef struct packed {
        uop_kind_t kind;
        reg_id_t   s1;
        reg_id_t   s2;
        reg_id_t   dst;
    } uop_t;

    typedef struct packed {
        logic load;
        logic start;
        logic push;
        uop_t uop;
    } ctrl_cmd_t;

    typedef struct packed {
        logic       early;
        logic       unit_done;
        logic       zero;
        logic       out_full;
        logic [2:0] op;
    } dp_sts_t;

    function automatic uop_t mk(uop_kind_t k, reg_id_t a, reg_id_t b, reg_id_t d);
        uop_t u;
        u.kind = k;
        u.s1   = a;
        u.s2   = b;
        u.dst  = d;
        return u;
    endfunction

    function automatic uop_t prog_fetch(logic [2:0] op, logic [PC_W-1:0] pc);
        uop_t u;
        u = mk(U_FRAC, R_NA, R_DA, R_NA);
        case (pc)
            5'd0: u = mk(U_GCD, R_NA, R_DA, R_G1);
            5'd1: u = mk(U_DIV, R_NA, R_G1, R_NA);
            5'd2: u = mk(U_DIV, R_DA, R_G1, R_DA);
            default:
            begin
                case (op)
                    OPC_NORM: u = mk(U_FRAC, R_NA, R_DA, R_NA);
                    OPC_ADD, OPC_SUB:
                    begin
                        case (pc)
                            5'd3:  u = mk(U_GCD, R_NB, R_DB, R_G2);
                            5'd4:  u = mk(U_DIV, R_NB, R_G2, R_NB);
                            5'd5:  u = mk(U_DIV, R_DB, R_G2, R_DB);
                            5'd6:  u = mk(U_GCD, R_DA, R_DB, R_G1);
                            5'd7:  u = mk(U_DIV, R_DB, R_G1, R_X);
                            5'd8:  u = mk(U_DIV, R_DA, R_G1, R_Y);
                            5'd9:  u = mk(U_MUL, R_NA, R_X, R_P);
                            5'd10: u = mk(U_MUL, R_NB, R_Y, R_Q);
                            5'd11: u = mk(U_COMB, R_P, R_Q, R_T);
                            5'd12: u = mk(U_ZEND, R_T, R_T, R_T);
                            5'd13: u = mk(U_DIV, R_T, R_G1, R_Q);
                            5'd14: u = mk(U_GCD, R_REM, R_G1, R_G2);
                            5'd15: u = mk(U_DIV, R_T, R_G2, R_T);
                            5'd16: u = mk(U_DIV, R_DB, R_G2, R_X);
                            5'd17: u = mk(U_MUL, R_Y, R_X, R_P);
                            default: u = mk(U_FRAC, R_T, R_P, R_T);
                        endcase
                    end
                    OPC_MUL, OPC_DIV:
                    begin
                        case (pc)
                            5'd3:  u = mk(U_GCD, R_NB, R_DB, R_G2);
                            5'd4:  u = mk(U_DIV, R_NB, R_G2, R_NB);
                            5'd5:  u = mk(U_DIV, R_DB, R_G2, R_DB);
                            5'd6:  u = mk(U_ZEND, R_NA, R_NA, R_NA);
                            5'd7:  u = mk(U_ZEND, R_NB, R_NB, R_NB);
                            5'd8:  u = mk(U_GCD, R_NA, R_DB, R_G1);
                            5'd9:  u = mk(U_GCD, R_NB, R_DA, R_G2);
                            5'd10: u = mk(U_DIV, R_NA, R_G1, R_NA);
                            5'd11: u = mk(U_DIV, R_NB, R_G2, R_NB);
                            5'd12: u = mk(U_DIV, R_DA, R_G2, R_DA);
                            5'd13: u = mk(U_DIV, R_DB, R_G1, R_DB);
                            5'd14: u = mk(U_MUL, R_NA, R_NB, R_T);
                            5'd15: u = mk(U_MUL, R_DA, R_DB, R_P);
                            default: u = mk(U_FRAC, R_T, R_P, R_T);
                        endcase
                    end
                    default:
                    begin
                        case (pc)
                            5'd3: u = mk(U_GCD, R_NB, R_DB, R_G2);
                            5'd4: u = mk(U_DIV, R_NB, R_G2, R_NB);
                            5'd5: u = mk(U_DIV, R_DB, R_G2, R_DB);
                            5'd6: u = mk(U_MUL, R_NA, R_DB, R_P);
                            5'd7: u = mk(U_MUL, R_NB, R_DA, R_Q);
                            default: u = mk(U_LESS, R_P, R_Q, R_P);
                        endcase
                    end
                endcase
            end
        endcase
        return u;
    endfunction

endpackage

### sv/rau_in_if.sv
// ----------------------------------------------------------------------------
// rau_in_if
// Request channel: opcode and two fractions per word.
// ----------------------------------------------------------------------------
interface rau_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [63:0] a_num;
    logic [63:0] a_den;
    logic [63:0] b_num;
    logic [62:0] b_den;

    modport source (output valid, opcode, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, opcode, a_num, a_den, b_num, b_den, output ready);
endinterface

### sv/rau_out_if.sv
// ----------------------------------------------------------------------------
// rau_out_if
// Response channel: reduced fraction, compare flag and status per word.
// ----------------------------------------------------------------------------
interface rau_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] res_num;
    logic [62:0] res_den;
    logic        less_flag;
    logic [1:0]  status;

    modport source (output valid, res_num, res_den, less_flag, status, input ready);
    modport sink   (input valid, res_num, res_den, less_flag, status, output ready);
endinterface

### sv/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Exact add, subtract, multiply, divide, compare and normalize of fractions.
//
//   channel  role  payload
//   req      sink  opcode, a_num, a_den, b_num, b_den
//   rsp      src   res_num, res_den, less_flag, status
//
// One word at a time. Zero denominators and unused opcodes go straight from
// the check to the response, without running the micro-program.
// Reset clears the sequencer and the output valid. A held response does not
// stop the next request from being taken; it only delays the following push.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit (
    input logic      clk,
    input logic      rst_n,
    rau_in_if.sink   req,
    rau_out_if.source rsp
);
    import rau_pkg::*;

    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    rau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rau_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .opcode    (req.opcode),
        .a_num     (req.a_num),
        .a_den     (req.a_den),
        .b_num     (req.b_num),
        .b_den     (req.b_den),
        .out_ready (rsp.ready),
        .out_valid (rsp.valid),
        .res_num   (rsp.res_num),
        .res_den   (rsp.res_den),
        .less_flag (rsp.less_flag),
        .status    (rsp.status)
    );

endmodule

### sv/rau_ctrl.sv
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer: steps through the micro-program and drives the datapath.
// ----------------------------------------------------------------------------
module rau_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              out_ready,
    input  rau_pkg::dp_sts_t  sts,
    output rau_pkg::ctrl_cmd_t cmd
);
    import rau_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_ISSUE = 5'b00100,
        S_WAIT  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    uop_t            uop;

    assign uop      = prog_fetch(sts.op, pc_reg);
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        cmd.load   = 1'b0;
        cmd.start  = 1'b0;
        cmd.push   = 1'b0;
        cmd.uop    = uop;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    pc_next    = '0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = sts.early ? S_DONE : S_ISSUE;
            end
            S_ISSUE:
            begin
                case (uop.kind)
                    U_GCD, U_DIV, U_MUL:
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_WAIT;
                    end
                    U_COMB:
                    begin
                        cmd.start = 1'b1;
                        pc_next   = pc_reg + 1'b1;
                    end
                    U_ZEND:
                    begin
                        if (sts.zero)
                            state_next = S_DONE;
                        else
                            pc_next = pc_reg + 1'b1;
                    end
                    default:
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_WAIT:
            begin
                if (sts.unit_done)
                begin
                    pc_next    = pc_reg + 1'b1;
                    state_next = S_ISSUE;
                end
            end
            S_DONE:
            begin
                if (!sts.out_full || out_ready)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

endmodule

### sv/rau_dp.sv
// ----------------------------------------------------------------------------
// rau_dp
// Datapath: operand registers, binary gcd, radix-2 divider, 32x32 multiplier
// and the result and output registers.
// ----------------------------------------------------------------------------
module rau_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  rau_pkg::ctrl_cmd_t cmd,
    output rau_pkg::dp_sts_t   sts,
    input  logic [2:0]         opcode,
    input  logic [63:0]        a_num,
    input  logic [63:0]        a_den,
    input  logic [63:0]        b_num,
    input  logic [62:0]        b_den,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [63:0]        res_num,
    output logic [62:0]        res_den,
    output logic               less_flag,
    output logic [1:0]         status
);
    import rau_pkg::*;

    logic [63:0]  na_reg, da_reg, nb_reg, db_reg, g1_reg, g2_reg, x_reg, y_reg, rem_reg;
    logic [127:0] t_reg, p_reg, q_reg;
    logic         sa_reg, sb_reg, neg_reg, early_reg;
    logic [2:0]   op_reg;
    logic [63:0]  rn_reg, on_reg;
    logic [62:0]  rd_reg, od_reg;
    logic         rl_reg, ol_reg;
    logic [1:0]   rs_reg, os_reg;
    logic         ov_reg, ov_next;

    logic         ubusy_reg, ubusy_next;
    uop_kind_t    ukind_reg;
    reg_id_t      udst_reg;
    logic [6:0]   cnt_reg;
    logic [63:0]  gx_reg, gy_reg, dr_reg, dd_reg, ma_reg, mb_reg;
    logic [5:0]   gk_reg;
    logic [127:0] dq_reg, acc_reg;

    logic [127:0] opa, opb;

    function automatic logic [127:0] rd_sel(reg_id_t r, logic [63:0] na, logic [63:0] da,
                                            logic [63:0] nb, logic [63:0] db,
                                            logic [63:0] g1, logic [63:0] g2,
                                            logic [63:0] x, logic [63:0] y,
                                            logic [63:0] rm, logic [127:0] t,
                                            logic [127:0] p, logic [127:0] q);
        logic [127:0] v;
        case (r)
            R_NA:    v = {64'd0, na};
            R_DA:    v = {64'd0, da};
            R_NB:    v = {64'd0, nb};
            R_DB:    v = {64'd0, db};
            R_G1:    v = {64'd0, g1};
            R_G2:    v = {64'd0, g2};
            R_X:     v = {64'd0, x};
            R_Y:     v = {64'd0, y};
            R_REM:   v = {64'd0, rm};
            R_T:     v = t;
            R_P:     v = p;
            R_Q:     v = q;
            default: v = '0;
        endcase
        return v;
    endfunction

    assign opa = rd_sel(cmd.uop.s1, na_reg, da_reg, nb_reg, db_reg, g1_reg, g2_reg,
                        x_reg, y_reg, rem_reg, t_reg, p_reg, q_reg);
    assign opb = rd_sel(cmd.uop.s2, na_reg, da_reg, nb_reg, db_reg, g1_reg, g2_reg,
                        x_reg, y_reg, rem_reg, t_reg, p_reg, q_reg);

    // operand capture and sign handling
    logic [63:0] anm, adm, bnm, bdm, nb_l, db_l;
    logic        sa_l, sb0, sb_l, neg_l, early_l;
    logic [1:0]  est_l;

    always_comb
    begin
        anm  = a_num[63] ? (~a_num + 64'd1) : a_num;
        adm  = a_den[63] ? (~a_den + 64'd1) : a_den;
        bnm  = b_num[63] ? (~b_num + 64'd1) : b_num;
        bdm  = {1'b0, b_den};
        sa_l = (anm != 64'd0) && (a_num[63] != a_den[63]);
        sb0  = (bnm != 64'd0) && b_num[63];
        sb_l = (opcode == OPC_SUB) ? (sb0 ^ (bnm != 64'd0)) : sb0;
        nb_l = (opcode == OPC_DIV) ? bdm : bnm;
        db_l = (opcode == OPC_DIV) ? bnm : bdm;
        neg_l = (opcode == OPC_MUL || opcode == OPC_DIV) ? (sa_l ^ sb_l) : sa_l;
        early_l = 1'b0;
        est_l   = ST_OK;
        if (opcode > OPC_NORM)
            early_l = 1'b1;
        else if (adm == 64'd0 || (opcode != OPC_NORM && bdm == 64'd0) ||
                 (opcode == OPC_DIV && bnm == 64'd0))
        begin
            early_l = 1'b1;
            est_l   = ST_ZDEN;
        end
    end

    // iterative units
    logic         g_fin;
    logic [63:0]  g_res, gx_n, gy_n;
    logic [5:0]   gk_n;
    logic [64:0]  r65;
    logic         d_ge;
    logic [63:0]  dr_n;
    logic [127:0] dq_n;
    logic [31:0]  ahalf, bhalf;
    logic [63:0]  prod;
    logic [6:0]   shamt;
    logic [127:0] acc_n;
    logic         u_fin;
    logic [127:0] u_res;

    always_comb
    begin
        g_fin = (gx_reg == 64'd0) || (gy_reg == 64'd0);
        g_res = (gx_reg | gy_reg) << gk_reg;
        gx_n  = gx_reg;
        gy_n  = gy_reg;
        gk_n  = gk_reg;
        if (!gx_reg[0] && !gy_reg[0])
        begin
            gx_n = gx_reg >> 1;
            gy_n = gy_reg >> 1;
            gk_n = gk_reg + 6'd1;
        end
        else if (!gx_reg[0])
            gx_n = gx_reg >> 1;
        else if (!gy_reg[0])
            gy_n = gy_reg >> 1;
        else if (gx_reg >= gy_reg)
            gx_n = (gx_reg - gy_reg) >> 1;
        else
            gy_n = (gy_reg - gx_reg) >> 1;

        r65  = {dr_reg, dq_reg[127]};
        d_ge = r65 >= {1'b0, dd_reg};
        dr_n = d_ge ? 64'(r65 - {1'b0, dd_reg}) : r65[63:0];
        dq_n = {dq_reg[126:0], d_ge};

        ahalf = cnt_reg[0] ? ma_reg[63:32] : ma_reg[31:0];
        bhalf = cnt_reg[1] ? mb_reg[63:32] : mb_reg[31:0];
        prod  = ahalf * bhalf;
        shamt = {cnt_reg[0] & cnt_reg[1], cnt_reg[0] ^ cnt_reg[1], 5'd0};
        acc_n = acc_reg + ({64'd0, prod} << shamt);

        case (ukind_reg)
            U_GCD:
            begin
                u_fin = g_fin;
                u_res = {64'd0, g_res};
            end
            U_DIV:
            begin
                u_fin = (cnt_reg == 7'd127);
                u_res = dq_n;
            end
            default:
            begin
                u_fin = (cnt_reg[1:0] == 2'd3);
                u_res = acc_n;
            end
        endcase
    end

    // combine, emit and compare
    logic [127:0] comb_t;
    logic         comb_neg, nfit, dfit, less_v;

    always_comb
    begin
        if (sa_reg == sb_reg)
        begin
            comb_t   = p_reg + q_reg;
            comb_neg = sa_reg;
        end
        else if (p_reg >= q_reg)
        begin
            comb_t   = p_reg - q_reg;
            comb_neg = sa_reg;
        end
        else
        begin
            comb_t   = q_reg - p_reg;
            comb_neg = sb_reg;
        end
        nfit = (opa <= LIM - 128'd1) || (neg_reg && opa == LIM);
        dfit = (opb >= 128'd1) && (opb <= LIM - 128'd1);
        if (sa_reg != sb_reg)
            less_v = sa_reg;
        else if (sa_reg)
            less_v = opa > opb;
        else
            less_v = opa < opb;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            na_reg    <= anm;
            da_reg    <= adm;
            nb_reg    <= nb_l;
            db_reg    <= db_l;
            sa_reg    <= sa_l;
            sb_reg    <= sb_l;
            neg_reg   <= neg_l;
            op_reg    <= opcode;
            early_reg <= early_l;
            rn_reg    <= 64'd0;
            rd_reg    <= 63'd1;
            rl_reg    <= 1'b0;
            rs_reg    <= est_l;
        end
        if (cmd.start)
        begin
            ukind_reg <= cmd.uop.kind;
            udst_reg  <= cmd.uop.dst;
            cnt_reg   <= '0;
            gx_reg    <= opa[63:0];
            gy_reg    <= opb[63:0];
            gk_reg    <= '0;
            dq_reg    <= opa;
            dr_reg    <= '0;
            dd_reg    <= opb[63:0];
            ma_reg    <= opa[63:0];
            mb_reg    <= opb[63:0];
            acc_reg   <= '0;
            case (cmd.uop.kind)
                U_COMB:
                begin
                    t_reg   <= comb_t;
                    neg_reg <= comb_neg;
                end
                U_FRAC:
                begin
                    if (!(nfit && dfit))
                        rs_reg <= ST_OVF;
                    else if (opa != 128'd0)
                    begin
                        rn_reg <= neg_reg ? (~opa[63:0] + 64'd1) : opa[63:0];
                        rd_reg <= opb[62:0];
                    end
                end
                U_LESS: rl_reg <= less_v;
                default: ;
            endcase
        end
        if (ubusy_reg)
        begin
            cnt_reg <= cnt_reg + 7'd1;
            gx_reg  <= gx_n;
            gy_reg  <= gy_n;
            gk_reg  <= gk_n;
            dq_reg  <= dq_n;
            dr_reg  <= dr_n;
            acc_reg <= acc_n;
            if (u_fin)
            begin
                if (ukind_reg == U_DIV)
                    rem_reg <= dr_n;
                case (udst_reg)
                    R_NA:    na_reg  <= u_res[63:0];
                    R_DA:    da_reg  <= u_res[63:0];
                    R_NB:    nb_reg  <= u_res[63:0];
                    R_DB:    db_reg  <= u_res[63:0];
                    R_G1:    g1_reg  <= u_res[63:0];
                    R_G2:    g2_reg  <= u_res[63:0];
                    R_X:     x_reg   <= u_res[63:0];
                    R_Y:     y_reg   <= u_res[63:0];
                    R_REM:   rem_reg <= u_res[63:0];
                    R_T:     t_reg   <= u_res;
                    R_P:     p_reg   <= u_res;
                    R_Q:     q_reg   <= u_res;
                    default: ;
                endcase
            end
        end
        if (cmd.push)
        begin
            on_reg <= rn_reg;
            od_reg <= rd_reg;
            ol_reg <= rl_reg;
            os_reg <= rs_reg;
        end
    end

    always_comb
    begin
        ubusy_next = ubusy_reg;
        if (ubusy_reg && u_fin)
            ubusy_next = 1'b0;
        if (cmd.start && (cmd.uop.kind == U_GCD || cmd.uop.kind == U_DIV ||
                          cmd.uop.kind == U_MUL))
            ubusy_next = 1'b1;
        ov_next = cmd.push | (ov_reg & ~out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ubusy_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            ubusy_reg <= ubusy_next;
            ov_reg    <= ov_next;
        end
    end

    assign sts.early     = early_reg;
    assign sts.unit_done = ubusy_reg & u_fin;
    assign sts.zero      = (opa == 128'd0);
    assign sts.out_full  = ov_reg;
    assign sts.op        = op_reg;

    assign out_valid = ov_reg;
    assign res_num   = on_reg;
    assign res_den   = od_reg;
    assign less_flag = ol_reg;
    assign status    = os_reg;

endmodule

### sv/rau_checker.sv
// ----------------------------------------------------------------------------
// rau_checker
// Port-level checks of the rational arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module rau_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] res_num,
    input logic [62:0] res_den,
    input logic        less_flag,
    input logic [1:0]  status
);
    import rau_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(res_num) && $stable(status))
        else $error("response dropped while stalled");

    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while busy");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> res_num == 64'd0 && res_den == 63'd1 && !less_flag)
        else $error("error response carries a value");

    a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> res_den != 63'd0 &&
                      (status == ST_OK || status == ST_OVF || status == ST_ZDEN))
        else $error("zero denominator or bad status");

    a_less_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && less_flag |-> res_num == 64'd0 && res_den == 63'd1)
        else $error("compare flag with a fraction");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .res_num   (rsp.res_num),
    .res_den   (rsp.res_den),
    .less_flag (rsp.less_flag),
    .status    (rsp.status)
);
